// ----- src/icv_pkg.sv -----
`default_nettype none
package icv_pkg;

  // Store geometry
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int MAX_KERNEL  = 7;

  // Field widths
  localparam int COL_W  = 6;
  localparam int ROW_W  = 6;
  localparam int DIM_W  = 7;
  localparam int KS_W   = 3;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 37;

  // Memory sizes; the image address is {row, column} since MAX_COLUMNS is 2**COL_W
  localparam int IMG_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int IMG_AW    = COL_W + ROW_W;
  localparam int KRN_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int KRN_AW    = 6;

  // Opcodes
  localparam logic [1:0] OP_KERNEL  = 2'd0;
  localparam logic [1:0] OP_IMAGE   = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EVEN     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_KSIZE   = 2'd2;
  localparam logic [1:0] REG_PADDING = 2'd3;

  // Jump conditions
  localparam logic [2:0] C_NEVER     = 3'd0;
  localparam logic [2:0] C_ALWAYS    = 3'd1;
  localparam logic [2:0] C_NO_REQ    = 3'd2;
  localparam logic [2:0] C_FAULT     = 3'd3;
  localparam logic [2:0] C_COMPUTE   = 3'd4;
  localparam logic [2:0] C_MORE_TAPS = 3'd5;
  localparam logic [2:0] C_OUT_FULL  = 3'd6;

  // Program steps
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] S_FETCH    = 3'd0;
  localparam logic [PC_W-1:0] S_CHECK    = 3'd1;
  localparam logic [PC_W-1:0] S_DISPATCH = 3'd2;
  localparam logic [PC_W-1:0] S_WRITE    = 3'd3;
  localparam logic [PC_W-1:0] S_TAP      = 3'd4;
  localparam logic [PC_W-1:0] S_DRAIN0   = 3'd5;
  localparam logic [PC_W-1:0] S_DRAIN1   = 3'd6;
  localparam logic [PC_W-1:0] S_EMIT     = 3'd7;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [COL_W-1:0]        column;
    logic [ROW_W-1:0]        row_index;
    logic signed [VAL_W-1:0] write_value;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_sum;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic [DIM_W-1:0]        image_columns;
    logic [DIM_W-1:0]        image_rows;
    logic [KS_W-1:0]         kernel_size;
    logic signed [VAL_W-1:0] padding_value;
  } cfg_t;

  // One control word of the program
  typedef struct packed {
    logic            take;   // ready for a new request
    logic            check;  // latch status, clear accumulator and tap counters
    logic            wr;     // write the store selected by the opcode
    logic            issue;  // read one tap and advance the tap counters
    logic            emit;   // load the result register
    logic            fin;    // fall through to the fetch step
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic fault;
    logic compute;
    logic more_taps;
  } flags_t;

  function automatic ctl_t icv_ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '0;
    case (pc)
      S_FETCH: begin
        w.take = 1'b1; w.cond = C_NO_REQ; w.target = S_FETCH;
      end
      S_CHECK: begin
        w.check = 1'b1; w.cond = C_FAULT; w.target = S_EMIT;
      end
      S_DISPATCH: begin
        w.cond = C_COMPUTE; w.target = S_TAP;
      end
      S_WRITE: begin
        w.wr = 1'b1; w.cond = C_ALWAYS; w.target = S_EMIT;
      end
      S_TAP: begin
        w.issue = 1'b1; w.cond = C_MORE_TAPS; w.target = S_TAP;
      end
      S_DRAIN0: begin
        w.cond = C_NEVER; w.target = S_FETCH;
      end
      S_DRAIN1: begin
        w.cond = C_NEVER; w.target = S_FETCH;
      end
      S_EMIT: begin
        w.emit = 1'b1; w.fin = 1'b1; w.cond = C_OUT_FULL; w.target = S_EMIT;
      end
      default: begin
        w.fin = 1'b1; w.cond = C_NEVER; w.target = S_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- src/icv_seq.sv -----
`default_nettype none
module icv_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  input  wire logic            out_full,
  input  wire icv_pkg::flags_t flags,
  output icv_pkg::ctl_t        ctl
);
  import icv_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            taken;

  // Fetch the control word for the current step
  assign ctl = icv_ucode(pc);

  // Evaluate the jump condition
  always_comb begin
    case (ctl.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_REQ:    taken = !req_valid;
      C_FAULT:     taken = flags.fault;
      C_COMPUTE:   taken = flags.compute;
      C_MORE_TAPS: taken = flags.more_taps;
      C_OUT_FULL:  taken = out_full;
      default:     taken = 1'b0;
    endcase
  end

  // Jump, return to fetch, or step on
  always_comb begin
    if (taken) begin
      pc_next = ctl.target;
    end else if (ctl.fin) begin
      pc_next = S_FETCH;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/icv_dp.sv -----
`default_nettype none
module icv_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire icv_pkg::ctl_t                 ctl,
  input  wire icv_pkg::cfg_t                 cfg,
  input  wire logic                          accept,
  input  wire icv_pkg::in_t                  req_in,
  output icv_pkg::flags_t                    flags,
  output logic signed [icv_pkg::SUM_W-1:0]   acc,
  output logic [1:0]                         status
);
  import icv_pkg::*;

  in_t                     req;
  logic [DIM_W-1:0]        ncols;
  logic [DIM_W-1:0]        nrows;
  logic [KS_W-1:0]         ks;
  logic [KS_W-1:0]         half;
  logic [1:0]              status_next;
  logic [KS_W-1:0]         kr;
  logic [KS_W-1:0]         kc;
  logic                    last_col;
  logic                    last_tap;
  logic [DIM_W:0]          x;
  logic [DIM_W:0]          y;
  logic                    in_image;
  logic [IMG_AW-1:0]       img_raddr;
  logic [IMG_AW-1:0]       img_waddr;
  logic [KRN_AW-1:0]       krn_raddr;
  logic [KRN_AW-1:0]       krn_waddr;
  logic [VAL_W-1:0]        img_mem [IMG_DEPTH];
  logic [VAL_W-1:0]        krn_mem [KRN_DEPTH];
  logic signed [VAL_W-1:0] img_q;
  logic signed [VAL_W-1:0] krn_q;
  logic                    pad_sel;
  logic                    v1;
  logic signed [VAL_W-1:0] pix;
  logic signed [PROD_W-1:0] prod;
  logic                    v2;

  // Hold the request taken at fetch
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= req_in;
    end
  end

  // Saturate image dimensions to the range 1 to the store size
  always_comb begin
    if (cfg.image_columns == '0) begin
      ncols = DIM_W'(1);
    end else if (cfg.image_columns > DIM_W'(MAX_COLUMNS)) begin
      ncols = DIM_W'(MAX_COLUMNS);
    end else begin
      ncols = cfg.image_columns;
    end
    if (cfg.image_rows == '0) begin
      nrows = DIM_W'(1);
    end else if (cfg.image_rows > DIM_W'(MAX_ROWS)) begin
      nrows = DIM_W'(MAX_ROWS);
    end else begin
      nrows = cfg.image_rows;
    end
  end

  assign ks   = (cfg.kernel_size > KS_W'(MAX_KERNEL)) ? KS_W'(MAX_KERNEL) : cfg.kernel_size;
  assign half = ks >> 1;

  // Classify the request; an even size wins over a bad position
  always_comb begin
    case (req.opcode)
      OP_KERNEL: begin
        status_next = (KS_W'(req.column) < ks && KS_W'(req.row_index) < ks &&
                       req.column < COL_W'(MAX_KERNEL) && req.row_index < ROW_W'(MAX_KERNEL))
                      ? ST_OK : ST_RANGE;
      end
      OP_IMAGE: begin
        status_next = (DIM_W'(req.column) < ncols && DIM_W'(req.row_index) < nrows)
                      ? ST_OK : ST_RANGE;
      end
      OP_COMPUTE: begin
        if (!ks[0]) begin
          status_next = ST_EVEN;
        end else if (DIM_W'(req.column) >= ncols || DIM_W'(req.row_index) >= nrows) begin
          status_next = ST_RANGE;
        end else begin
          status_next = ST_OK;
        end
      end
      default: status_next = ST_RANGE;
    endcase
  end

  assign last_col = (kc == ks - 1'b1);
  assign last_tap = last_col && (kr == ks - 1'b1);

  assign flags.fault     = (status_next != ST_OK);
  assign flags.compute   = (req.opcode == OP_COMPUTE);
  assign flags.more_taps = !last_tap;

  always_ff @(posedge clk) begin
    if (ctl.check) begin
      status <= status_next;
    end
  end

  // Advance the window position, column first
  always_ff @(posedge clk) begin
    if (ctl.check) begin
      kr <= '0;
      kc <= '0;
    end else if (ctl.issue) begin
      if (last_col) begin
        kc <= '0;
        kr <= kr + 1'b1;
      end else begin
        kc <= kc + 1'b1;
      end
    end
  end

  // Window position in the image; bit DIM_W flags a negative coordinate
  assign x = (DIM_W+1)'(req.column) + (DIM_W+1)'(kc) - (DIM_W+1)'(half);
  assign y = (DIM_W+1)'(req.row_index) + (DIM_W+1)'(kr) - (DIM_W+1)'(half);
  assign in_image = !x[DIM_W] && !y[DIM_W] && (x[DIM_W-1:0] < ncols) && (y[DIM_W-1:0] < nrows);

  assign img_raddr = {y[ROW_W-1:0], x[COL_W-1:0]};
  assign img_waddr = {req.row_index, req.column};
  assign krn_raddr = KRN_AW'(kr) * KRN_AW'(MAX_KERNEL) + KRN_AW'(kc);
  assign krn_waddr = KRN_AW'(req.row_index) * KRN_AW'(MAX_KERNEL) + KRN_AW'(req.column);

  // Image store: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (ctl.wr && req.opcode == OP_IMAGE) begin
      img_mem[img_waddr] <= req.write_value;
    end
    if (ctl.issue) begin
      img_q <= img_mem[img_raddr];
    end
  end

  // Kernel store
  always_ff @(posedge clk) begin
    if (ctl.wr && req.opcode == OP_KERNEL) begin
      krn_mem[krn_waddr] <= req.write_value;
    end
    if (ctl.issue) begin
      krn_q <= krn_mem[krn_raddr];
    end
  end

  // Tap read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      pad_sel <= !in_image;
    end
  end

  // Multiply stage
  assign pix = pad_sel ? cfg.padding_value : img_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= pix * krn_q;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.check) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + SUM_W'(prod);
    end
  end

endmodule
`default_nettype wire

// ----- src/integer_convolution_2d.sv -----
`default_nettype none
// Channel   Signals                                 Direction  Moves
// in        in_valid, in_ready, in_data (in_t)      into       one request
// out       out_valid, out_ready, out_data (out_t)  out of     one result per request
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  into    one register write
//
// A compute request reads one tap per cycle through the single image memory read port
// into one multiply-accumulate. Reset loads the register reset values; both stores
// stay undefined until written. A result waiting in the output register does not stop
// the next request; only the load of the following result waits for out_ready.
module integer_convolution_2d (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire icv_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output icv_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);
  import icv_pkg::*;

  cfg_t                    cfg;
  ctl_t                    ctl;
  flags_t                  flags;
  logic                    accept;
  logic                    out_full;
  logic signed [SUM_W-1:0] acc;
  logic [1:0]              status;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctl.take;
  assign accept    = in_valid && in_ready;
  assign out_full  = out_valid && !out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_columns <= DIM_W'(64);
      cfg.image_rows    <= DIM_W'(64);
      cfg.kernel_size   <= KS_W'(3);
      cfg.padding_value <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COLUMNS: cfg.image_columns <= cfg_data[DIM_W-1:0];
        REG_ROWS:    cfg.image_rows    <= cfg_data[DIM_W-1:0];
        REG_KSIZE:   cfg.kernel_size   <= cfg_data[KS_W-1:0];
        REG_PADDING: cfg.padding_value <= cfg_data;
        default: ;
      endcase
    end
  end

  icv_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .out_full  (out_full),
    .flags     (flags),
    .ctl       (ctl)
  );

  icv_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cfg    (cfg),
    .accept (accept),
    .req_in (in_data),
    .flags  (flags),
    .acc    (acc),
    .status (status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit && !out_full) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && !out_full) begin
      out_data.conv_sum <= acc;
      out_data.status   <= status;
    end
  end

endmodule
`default_nettype wire

// ----- test/tb_integer_convolution_2d.sv -----
`timescale 1ns / 1ps
module tb_integer_convolution_2d;
  import icv_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow copy of the register file
  logic [DIM_W-1:0] cols_reg = 7'd64;
  logic [DIM_W-1:0] rows_reg = 7'd64;
  logic [KS_W-1:0] ksize_reg = 3'd3;
  logic signed [VAL_W-1:0] pad_reg = '0;

  // Shadow copy of both stores, with a mark for every entry written so far
  logic signed [VAL_W-1:0] img_mem [0:IMG_DEPTH-1];
  bit img_set [0:IMG_DEPTH-1];
  logic signed [VAL_W-1:0] krn_mem [0:KRN_DEPTH-1];
  bit krn_set [0:KRN_DEPTH-1];

  out_t conv_results_due [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int sent_count = 0;

  integer_convolution_2d uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate an image dimension register to 1..lim
  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // Apply one request to the shadow state and return the result it must produce
  function automatic out_t convolve_request(input in_t req);
    out_t res;
    int ncols, nrows, ks, half, x, y, col, row;
    logic signed [SUM_W-1:0] acc;
    logic signed [VAL_W-1:0] pix, coef;
    res = '0;
    res.status = ST_OK;
    col = int'(req.column);
    row = int'(req.row_index);
    ncols = clamp_dim(cols_reg, MAX_COLUMNS);
    nrows = clamp_dim(rows_reg, MAX_ROWS);
    ks = int'(ksize_reg);
    case (req.opcode)
      OP_KERNEL: begin
        if (col < ks && row < ks) begin
          krn_mem[row * MAX_KERNEL + col] = req.write_value;
          krn_set[row * MAX_KERNEL + col] = 1'b1;
        end else begin
          res.status = ST_RANGE;
        end
      end
      OP_IMAGE: begin
        if (col < ncols && row < nrows) begin
          img_mem[row * MAX_COLUMNS + col] = req.write_value;
          img_set[row * MAX_COLUMNS + col] = 1'b1;
        end else begin
          res.status = ST_RANGE;
        end
      end
      OP_COMPUTE: begin
        // an even size wins over a position outside the image
        if (ks % 2 == 0) begin
          res.status = ST_EVEN;
        end else if (col >= ncols || row >= nrows) begin
          res.status = ST_RANGE;
        end else begin
          half = ks / 2;
          acc = '0;
          for (int kr = 0; kr < ks; kr++) begin
            for (int kc = 0; kc < ks; kc++) begin
              x = col + kc - half;
              y = row + kr - half;
              coef = krn_mem[kr * MAX_KERNEL + kc];
              if (x < 0 || x >= ncols || y < 0 || y >= nrows) begin
                pix = pad_reg;
              end else begin
                pix = img_mem[y * MAX_COLUMNS + x];
              end
              acc += SUM_W'(pix) * SUM_W'(coef);
            end
          end
          res.conv_sum = acc;
        end
      end
      default: begin
        res.status = ST_RANGE;
      end
    endcase
    return res;
  endfunction

  // Offer one request, hold it until accepted, then log its result as due
  task automatic send_request(input in_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    conv_results_due.push_back(convolve_request(req));
  endtask

  // Write every coefficient and pixel a compute at (col, row) would read and has not yet
  task automatic fill_window(input int col, input int row);
    int ks, half, x, y, ncols, nrows;
    in_t w;
    ks = int'(ksize_reg);
    ncols = clamp_dim(cols_reg, MAX_COLUMNS);
    nrows = clamp_dim(rows_reg, MAX_ROWS);
    if (ks % 2 == 0 || col >= ncols || row >= nrows) return;
    half = ks / 2;
    for (int kr = 0; kr < ks; kr++) begin
      for (int kc = 0; kc < ks; kc++) begin
        if (!krn_set[kr * MAX_KERNEL + kc]) begin
          w.opcode = OP_KERNEL;
          w.column = COL_W'(kc);
          w.row_index = ROW_W'(kr);
          w.write_value = VAL_W'($urandom);
          send_request(w);
        end
        x = col + kc - half;
        y = row + kr - half;
        if (x >= 0 && x < ncols && y >= 0 && y < nrows && !img_set[y * MAX_COLUMNS + x]) begin
          w.opcode = OP_IMAGE;
          w.column = COL_W'(x);
          w.row_index = ROW_W'(y);
          w.write_value = VAL_W'($urandom);
          send_request(w);
        end
      end
    end
  endtask

  // Send a request; a compute first gets its whole window written
  task automatic issue_request(input in_t req);
    if (req.opcode == OP_COMPUTE) fill_window(int'(req.column), int'(req.row_index));
    send_request(req);
  endtask

  task automatic send_fields(input logic [1:0] op, input int col, input int row,
                             input int val);
    in_t req;
    req.opcode = op;
    req.column = col[COL_W-1:0];
    req.row_index = row[ROW_W-1:0];
    req.write_value = val[VAL_W-1:0];
    issue_request(req);
  endtask

  // Drop valid and wait until every request has returned its result
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (conv_results_due.size() != 0) @(posedge clk);
  endtask

  // Write all four registers back to back; unused high bits carry noise
  task automatic set_geometry(input int cols, input int rows, input int ks, input int pad);
    logic [15:0] word [4];
    wait_for_results();
    word[REG_COLUMNS] = 16'($urandom);
    word[REG_COLUMNS][DIM_W-1:0] = DIM_W'(cols);
    word[REG_ROWS] = 16'($urandom);
    word[REG_ROWS][DIM_W-1:0] = DIM_W'(rows);
    word[REG_KSIZE] = 16'($urandom);
    word[REG_KSIZE][KS_W-1:0] = KS_W'(ks);
    word[REG_PADDING] = pad[15:0];
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= word[i];
      do @(posedge clk); while (!cfg_ready);
      case (2'(i))
        REG_COLUMNS: cols_reg = word[i][DIM_W-1:0];
        REG_ROWS:    rows_reg = word[i][DIM_W-1:0];
        REG_KSIZE:   ksize_reg = word[i][KS_W-1:0];
        REG_PADDING: pad_reg = word[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct <= receiver_pct;
  endtask

  // Mostly in-range writes and computes, the rest arbitrary field values
  task automatic send_random_request();
    in_t req;
    int pick, ncols, nrows, ks;
    ncols = clamp_dim(cols_reg, MAX_COLUMNS);
    nrows = clamp_dim(rows_reg, MAX_ROWS);
    ks = int'(ksize_reg);
    pick = $urandom_range(99);
    req.write_value = VAL_W'($urandom);
    req.column = COL_W'($urandom_range(ncols - 1));
    req.row_index = ROW_W'($urandom_range(nrows - 1));
    if (pick < 35) begin
      req.opcode = OP_COMPUTE;
      if ($urandom_range(3) == 0) req.column = COL_W'($urandom_range(1) ? ncols - 1 : 0);
      if ($urandom_range(3) == 0) req.row_index = ROW_W'($urandom_range(1) ? nrows - 1 : 0);
    end else if (pick < 65) begin
      req.opcode = OP_IMAGE;
    end else if (pick < 80) begin
      req.opcode = OP_KERNEL;
      req.column = COL_W'($urandom_range(ks > 0 ? ks - 1 : 0));
      req.row_index = ROW_W'($urandom_range(ks > 0 ? ks - 1 : 0));
    end else begin
      req.opcode = 2'($urandom);
      req.column = COL_W'($urandom);
      req.row_index = ROW_W'($urandom);
    end
    issue_request(req);
  endtask

  // Full-scale values, corners with padding, and a 1x1 kernel at the far corner
  task automatic test_window_extremes();
    set_geometry(2, 2, 3, -32768);
    for (int kr = 0; kr < 3; kr++) begin
      for (int kc = 0; kc < 3; kc++) begin
        send_fields(OP_KERNEL, kc, kr, -32768);
      end
    end
    send_fields(OP_IMAGE, 0, 0, -32768);
    send_fields(OP_IMAGE, 1, 0, 32767);
    send_fields(OP_IMAGE, 0, 1, 0);
    send_fields(OP_IMAGE, 1, 1, -1);
    send_fields(OP_COMPUTE, 0, 0, 0);
    send_fields(OP_COMPUTE, 1, 1, 0);
    set_geometry(64, 64, 1, 32767);
    send_fields(OP_COMPUTE, 63, 63, 0);
  endtask

  // Out-of-range indexes, the unused opcode, even and zero kernel sizes
  task automatic test_fault_codes();
    set_geometry(3, 5, 3, 1);
    send_fields(OP_IMAGE, 3, 0, 5);
    send_fields(OP_IMAGE, 0, 5, 5);
    send_fields(OP_KERNEL, 3, 0, 5);
    send_fields(OP_COMPUTE, 63, 63, 0);
    send_fields(OP_UNUSED, 63, 63, -1);
    set_geometry(3, 5, 4, 1);
    send_fields(OP_KERNEL, 3, 3, 7);
    send_fields(OP_COMPUTE, 0, 0, 0);
    send_fields(OP_COMPUTE, 63, 0, 0);
    set_geometry(3, 5, 0, 1);
    send_fields(OP_COMPUTE, 1, 1, 0);
  endtask

  // Send at least count requests in all, window fills included
  task automatic test_random_traffic(input int cols, input int rows, input int ks,
                                     input int pad, input int count);
    int stop_count;
    set_geometry(cols, rows, ks, pad);
    stop_count = sent_count + count;
    while (sent_count < stop_count) send_random_request();
  endtask

  // Stall the result side for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    wait_for_results();
    hold_requests <= hold_requests + 1;
    repeat (16) send_random_request();
    wait_for_results();
  endtask

  // Receiver: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result with the oldest one due
  always @(posedge clk) begin : check_results
    out_t due;
    if (!rst && out_valid && out_ready) begin
      if (conv_results_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual conv_sum %0d status %0d",
                 $time, out_data.conv_sum, out_data.status);
      end else begin
        due = conv_results_due.pop_front();
        if (out_data.conv_sum !== due.conv_sum) begin
          error_count++;
          $display("%0t: conv_sum mismatch, expected %0d, actual %0d",
                   $time, due.conv_sum, out_data.conv_sum);
        end
        if (out_data.status !== due.status) begin
          error_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, due.status, out_data.status);
        end
      end
    end
  end

  // Stop the run when no channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_integer_convolution_2d: done, errors");
        $finish;
      end
    end
  end

  initial begin
    set_idle(8, 52);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_window_extremes();
    test_fault_codes();
    test_random_traffic(64, 64, 7, 0, 50);
    test_random_traffic(1, 1, 1, 32767, 90);
    set_idle(52, 8);
    test_random_traffic(0, 127, 5, -1, 110);
    test_random_traffic(100, 3, 7, -32768, 110);
    test_random_traffic(5, 9, 2, 123, 80);
    set_idle(0, 0);
    test_output_backpressure();
    test_random_traffic(17, 33, 3, int'($urandom_range(65535)) - 32768, 130);
    test_random_traffic(64, 1, 7, int'($urandom_range(65535)) - 32768, 110);
    test_random_traffic(8, 8, 3, int'($urandom_range(65535)) - 32768, 110);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_integer_convolution_2d: done, clean");
    end else begin
      $display("tb_integer_convolution_2d: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/icv_pkg.sv
src/icv_seq.sv
src/icv_dp.sv
src/integer_convolution_2d.sv
test/tb_integer_convolution_2d.sv
